### rtl/core/swa_pkg.sv
// ---------------------------------------------------------------------------
// swa_pkg
// Shared types and constants of the sliding window average core.
// ---------------------------------------------------------------------------
package swa_pkg;

   localparam int MAX_WINDOW   = 256;
   localparam int SAMPLE_BITS  = 32;
   localparam int AVG_BITS     = 32;
   localparam int LEN_BITS     = 9;
   localparam int PTR_BITS     = $clog2(MAX_WINDOW);
   localparam int CNT_BITS     = PTR_BITS + 1;
   localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(20);

   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic [CNT_BITS-1:0] period;
   } swa_job_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_UPDATE
   } swa_front_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } swa_div_state_type;

endpackage

### rtl/core/sliding_window_average_core.sv
// ---------------------------------------------------------------------------
// sliding_window_average_core
// Simple moving average of unsigned Q16.16 samples over a programmable
// window, truncated toward zero.
// ---------------------------------------------------------------------------
// Front end reads the window store on accept, then updates the sum; it
// takes no new sample during the update and stalls while the queue is
// full. Full-window jobs go through the queue to the 40-step bit-serial
// divider, which limits the result rate; other samples stop at the front.
// Synchronous reset: period 20, sum, fill count and pointer zero; the
// window store is not cleared.
// ---------------------------------------------------------------------------
module sliding_window_average_core import swa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_series_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [AVG_BITS-1:0]    rsp_average,
   input  logic                   csr_write_enable,
   input  logic [LEN_BITS-1:0]    csr_write_data
);

   logic        push_valid;
   swa_job_type push_data;
   logic        queue_full;
   logic        queue_empty;
   logic        pop;
   swa_job_type pop_data;

   swa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_series_start (req_series_start),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .queue_full       (queue_full)
   );

   swa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_data   (pop_data),
      .empty      (queue_empty)
   );

   swa_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job         (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

endmodule

### rtl/core/swa_front.sv
// ---------------------------------------------------------------------------
// swa_front
// Accepts samples, keeps the window store, running sum and fill count, and
// queues a divide job for every sample that completes a full window.
// ---------------------------------------------------------------------------
module swa_front import swa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_series_start,
   input  logic                   csr_write_enable,
   input  logic [LEN_BITS-1:0]    csr_write_data,
   output logic                   push_valid,
   output swa_job_type            push_data,
   input  logic                   queue_full
);

   swa_front_state_type    state_ff, state_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [CNT_BITS-1:0]    fill_ff, fill_in;
   logic [PTR_BITS-1:0]    wp_ff, wp_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SUM_BITS-1:0]    base_ff, base_in;
   logic [CNT_BITS-1:0]    fbase_ff, fbase_in;
   logic [CNT_BITS-1:0]    period_ff, period_in;
   logic                   evict_ff, evict_in;
   logic [SAMPLE_BITS-1:0] old_ff;

   logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

   logic [CNT_BITS-1:0]    period_now;
   logic [CNT_BITS-1:0]    fill_eff;
   logic [PTR_BITS-1:0]    old_addr;
   logic                   accept;
   logic                   mem_write;
   logic [SUM_BITS-1:0]    new_sum;
   logic [CNT_BITS-1:0]    new_fill;

   always_comb begin
      if (len_ff == '0) begin
         period_now = CNT_BITS'(1);
      end else if (CNT_BITS'(len_ff) > CNT_BITS'(MAX_WINDOW)) begin
         period_now = CNT_BITS'(MAX_WINDOW);
      end else begin
         period_now = CNT_BITS'(len_ff);
      end
   end

   assign fill_eff = req_series_start ? '0 : fill_ff;
   assign old_addr = wp_ff - period_now[PTR_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      sum_in     = sum_ff;
      fill_in    = fill_ff;
      wp_in      = wp_ff;
      sample_in  = sample_ff;
      base_in    = base_ff;
      fbase_in   = fbase_ff;
      period_in  = period_ff;
      evict_in   = evict_ff;
      accept     = 1'b0;
      mem_write  = 1'b0;
      push_valid = 1'b0;
      req_stall  = 1'b1;
      new_sum    = base_ff - (evict_ff ? SUM_BITS'(old_ff) : '0) + SUM_BITS'(sample_ff);
      new_fill   = evict_ff ? period_ff : fbase_ff + CNT_BITS'(1);
      push_data.sum    = new_sum;
      push_data.period = period_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            req_stall = queue_full;
            if (req_valid && !queue_full) begin
               accept    = 1'b1;
               sample_in = req_sample;
               base_in   = req_series_start ? '0 : sum_ff;
               fbase_in  = fill_eff;
               period_in = period_now;
               evict_in  = (fill_eff >= period_now);
               state_in  = FRONT_UPDATE;
            end
         end
         FRONT_UPDATE: begin
            mem_write  = 1'b1;
            sum_in     = new_sum;
            fill_in    = new_fill;
            wp_in      = wp_ff + PTR_BITS'(1);
            push_valid = (new_fill == period_ff);
            state_in   = FRONT_IDLE;
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         len_in  = csr_write_data;
         sum_in  = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
         len_ff   <= LEN_RESET;
         sum_ff   <= '0;
         fill_ff  <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         wp_ff    <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      base_ff   <= base_in;
      fbase_ff  <= fbase_in;
      period_ff <= period_in;
      evict_ff  <= evict_in;
   end

   // store read issues at accept, write lands in the update state that follows
   always_ff @(posedge clock) begin
      if (mem_write) begin
         mem[wp_ff] <= sample_ff;
      end
      if (accept) begin
         old_ff <= mem[old_addr];
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FRONT_UPDATE) |-> (fbase_ff <= period_ff))
      else $error("fill count above period");

   a_push_full_window: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (new_fill == period_ff && state_ff == FRONT_UPDATE))
      else $error("job queued without a full window");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("push into full queue");

endmodule

### rtl/core/swa_queue.sv
// ---------------------------------------------------------------------------
// swa_queue
// Short job queue between the window front end and the divider.
// ---------------------------------------------------------------------------
module swa_queue import swa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  swa_job_type push_data,
   output logic        full,
   input  logic        pop,
   output swa_job_type pop_data,
   output logic        empty
);

   swa_job_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff, head_in;
   logic [QPTR_BITS-1:0] tail_ff, tail_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_valid) begin
         tail_in = (tail_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         head_in = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QPTR_BITS'(1);
      end
      case ({push_valid, pop})
         2'b10:   count_in = count_ff + QCNT_BITS'(1);
         2'b01:   count_in = count_ff - QCNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |-> !full)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue underflow");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> (count_ff == $past(count_ff) + QCNT_BITS'(1)))
      else $error("queue count mismatch");

endmodule

### rtl/core/swa_divider.sv
// ---------------------------------------------------------------------------
// swa_divider
// Bit-serial restoring divider: window sum over period, one quotient bit
// per cycle, with a registered result stage on the output channel.
// ---------------------------------------------------------------------------
module swa_divider import swa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  swa_job_type         job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [AVG_BITS-1:0] rsp_average
);

   swa_div_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0]     rem_ff, rem_in;
   logic [SUM_BITS-1:0]     quo_ff, quo_in;
   logic [CNT_BITS-1:0]     div_ff, div_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    valid_ff, valid_in;
   logic [AVG_BITS-1:0]     avg_ff, avg_in;
   logic [CNT_BITS-1:0]     rem_shift;
   logic                    load;

   assign rsp_valid   = valid_ff;
   assign rsp_average = avg_ff;
   // remainder stays below divisor, so its top bit is always clear
   assign rem_shift   = {rem_ff[CNT_BITS-2:0], quo_ff[SUM_BITS-1]};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      avg_in   = avg_ff;
      valid_in = valid_ff;
      pop      = 1'b0;
      load     = 1'b0;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         DIV_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               rem_in   = '0;
               quo_in   = job.sum;
               div_in   = job.period;
               cnt_in   = '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (rem_shift >= div_ff) begin
               rem_in = rem_shift - div_ff;
               quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(SUM_BITS - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (!valid_ff || !rsp_stall) begin
               load     = 1'b1;
               avg_in   = quo_ff[AVG_BITS-1:0];
               valid_in = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      avg_ff <= avg_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) |-> (div_ff != '0))
      else $error("divide by zero");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_DONE) |-> (quo_ff[SUM_BITS-1:AVG_BITS] == '0))
      else $error("average overflows output width");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> (valid_ff && state_ff == DIV_IDLE))
      else $error("result not presented after load");

endmodule
